// ===== design/cdc_pkg.sv =====
package cdc_pkg;

  localparam int WINDOW_DEPTH = 256;
  localparam int WIN_AW       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  localparam int SIZE_W   = 17;
  localparam int OFFSET_W = 48;
  localparam int COUNT_W  = 32;
  localparam int HASH_W   = 32;  // only the bits the 32-bit mask can see
  localparam int BYTE_W   = 8;

  localparam int OUT_DATA_RAW_W = SIZE_W + OFFSET_W + COUNT_W;
  localparam int OUT_DATA_W     = ((OUT_DATA_RAW_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SIZE = 2'd0,
    CFG_MAX_SIZE = 2'd1,
    CFG_MASK     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REASON_NONE    = 2'd0,
    REASON_CONTENT = 2'd1,
    REASON_MAX     = 2'd2,
    REASON_EOS     = 2'd3
  } end_reason_t;

  localparam logic [SIZE_W-1:0] MIN_SIZE_RST = SIZE_W'(8 * 1024);
  localparam logic [SIZE_W-1:0] MAX_SIZE_RST = SIZE_W'(64 * 1024);
  localparam logic [HASH_W-1:0] MASK_RST     = HASH_W'(32 * 1024 - 1);

endpackage

// ===== design/content_defined_chunker.sv =====
// Path from input request to result: input/window-read register, then result register.
// One byte per cycle unless out_tready stalls; the window memory is read one item ahead.
// Reset (rst_n low, synchronous): clears chunk size, hash, window position, offsets, chunk
// count and handshake state, and restores the configuration defaults. The window memory
// is not cleared: entries are ignored until the chunk has refilled the window.
module content_defined_chunker (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cdc_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input bytes
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cdc_pkg::BYTE_W-1:0]          in_tdata,   // [7:0] data_byte
  input  logic                                in_tlast,   // stream_end
  // results
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cdc_pkg::OUT_DATA_W-1:0]      out_tdata,  // [16:0] chunk_size,
                                                          // [64:17] chunk_start,
                                                          // [96:65] chunk_number, rest 0
  output logic                                out_tlast,  // chunk_end
  output logic [1:0]                          out_tuser   // end_reason
);

  localparam int AW = cdc_pkg::WIN_AW;

  // configuration
  logic [cdc_pkg::SIZE_W-1:0] min_size_r;
  logic [cdc_pkg::SIZE_W-1:0] max_size_r;
  logic [cdc_pkg::HASH_W-1:0] mask_r;

  // chunk state
  logic [cdc_pkg::SIZE_W-1:0]   size_r,   size_nxt;
  logic [cdc_pkg::HASH_W-1:0]   hash_r,   hash_nxt;
  logic [AW-1:0]                pos_r,    pos_nxt;
  logic [cdc_pkg::OFFSET_W-1:0] offset_r, offset_nxt;
  logic [cdc_pkg::OFFSET_W-1:0] start_r,  start_nxt;
  logic [cdc_pkg::COUNT_W-1:0]  num_r,    num_nxt;

  // input stage
  logic                       s1_valid_r;
  logic [cdc_pkg::BYTE_W-1:0] s1_byte_r;
  logic                       s1_last_r;
  logic [cdc_pkg::BYTE_W-1:0] rd_r;

  // window memory
  logic [cdc_pkg::BYTE_W-1:0] win_mem [cdc_pkg::WINDOW_DEPTH];
  logic [AW-1:0]              rd_addr;

  // result register
  logic                         out_valid_r;
  logic [cdc_pkg::SIZE_W-1:0]   o_size_r;
  logic [cdc_pkg::OFFSET_W-1:0] o_start_r;
  logic [cdc_pkg::COUNT_W-1:0]  o_num_r;
  cdc_pkg::end_reason_t         o_reason_r;

  logic                       adv;
  logic                       in_acc;
  logic [cdc_pkg::BYTE_W-1:0] leaving;
  logic [cdc_pkg::SIZE_W-1:0] size_inc;
  logic [AW-1:0]              pos_inc;
  cdc_pkg::end_reason_t       reason;
  logic                       chunk_close;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    // leaving byte exists only once the chunk has filled the window
    leaving  = (size_r >= cdc_pkg::SIZE_W'(cdc_pkg::WINDOW_DEPTH)) ? rd_r : '0;
    hash_nxt = (hash_r << 1) ^ cdc_pkg::HASH_W'(s1_byte_r)
             ^ (cdc_pkg::HASH_W'(leaving) << 3);
    size_inc = size_r + cdc_pkg::SIZE_W'(1);
    pos_inc  = (pos_r == AW'(cdc_pkg::WINDOW_DEPTH - 1)) ? '0 : pos_r + AW'(1);

    if (size_inc >= min_size_r && (hash_nxt & mask_r) == '0) begin
      reason = cdc_pkg::REASON_CONTENT;
    end else if (size_inc >= max_size_r) begin
      reason = cdc_pkg::REASON_MAX;
    end else if (s1_last_r) begin
      reason = cdc_pkg::REASON_EOS;
    end else begin
      reason = cdc_pkg::REASON_NONE;
    end
    chunk_close = (reason != cdc_pkg::REASON_NONE);

    offset_nxt = offset_r + cdc_pkg::OFFSET_W'(1);
    if (chunk_close) begin
      size_nxt  = '0;
      pos_nxt   = '0;
      start_nxt = offset_nxt;
      num_nxt   = num_r + cdc_pkg::COUNT_W'(1);
    end else begin
      size_nxt  = size_inc;
      pos_nxt   = pos_inc;
      start_nxt = start_r;
      num_nxt   = num_r;
    end

    // window address of the byte being accepted now
    rd_addr = adv ? pos_nxt : pos_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win_mem[pos_r] <= s1_byte_r;
    end
    if (in_acc) begin
      rd_r <= win_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_size_r <= cdc_pkg::MIN_SIZE_RST;
      max_size_r <= cdc_pkg::MAX_SIZE_RST;
      mask_r     <= cdc_pkg::MASK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        cdc_pkg::CFG_MIN_SIZE: min_size_r <= cfg_data[cdc_pkg::SIZE_W-1:0];
        cdc_pkg::CFG_MAX_SIZE: max_size_r <= cfg_data[cdc_pkg::SIZE_W-1:0];
        cdc_pkg::CFG_MASK:     mask_r     <= cfg_data[cdc_pkg::HASH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= '0;
      hash_r      <= '0;
      pos_r       <= '0;
      offset_r    <= '0;
      start_r     <= '0;
      num_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        size_r      <= size_nxt;
        hash_r      <= chunk_close ? '0 : hash_nxt;
        pos_r       <= pos_nxt;
        offset_r    <= offset_nxt;
        start_r     <= start_nxt;
        num_r       <= num_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (adv) begin
      o_size_r   <= size_inc;
      o_start_r  <= start_r;
      o_num_r    <= num_r;
      o_reason_r <= reason;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = cdc_pkg::OUT_DATA_W'({o_num_r, o_start_r, o_size_r});
  assign out_tlast  = (o_reason_r != cdc_pkg::REASON_NONE);
  assign out_tuser  = o_reason_r;

endmodule
